@@ rtl/core/pwsw_pkg.sv @@
package pwsw_pkg;

   localparam int RegWidth   = 31;
   localparam int HdrBytes   = 44;
   localparam int HdrIdxBits = 6;

   localparam logic       CmdHeader = 1'b0;
   localparam logic       CmdSample = 1'b1;
   localparam logic [0:0] RegRate   = 1'b0;
   localparam logic [0:0] RegCount  = 1'b1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_beat_type;

   typedef struct packed {
      logic        cmd;
      logic [31:0] sample_bits;
   } req_beat_type;

   // fixed header byte, or zero where the byte comes from a register
   function automatic logic [7:0] hdr_const(input logic [HdrIdxBits-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         6'd0: b = 8'h52;  6'd1: b = 8'h49;  6'd2: b = 8'h46;  6'd3: b = 8'h46;
         6'd8: b = 8'h57;  6'd9: b = 8'h41;  6'd10: b = 8'h56; 6'd11: b = 8'h45;
         6'd12: b = 8'h66; 6'd13: b = 8'h6d; 6'd14: b = 8'h74; 6'd15: b = 8'h20;
         6'd16: b = 8'h10; 6'd20: b = 8'h01; 6'd22: b = 8'h01; 6'd32: b = 8'h02;
         6'd34: b = 8'h10;
         6'd36: b = 8'h64; 6'd37: b = 8'h61; 6'd38: b = 8'h74; 6'd39: b = 8'h61;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/core/pwsw_stream_if.sv @@
interface pwsw_stream_if #(
   parameter type beat_type = logic
);
   logic     valid;
   logic     ready;
   beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/pwsw_conv.sv @@
module pwsw_conv (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_vld,
   input  logic        in_cmd,
   input  logic [31:0] in_bits,
   output logic        out_vld,
   output logic        out_cmd,
   output logic [15:0] out_pcm
);
   // stage 1: classify and clamp, stage 2: multiply, stage 3: round and truncate
   logic        v1_ff, v2_ff, v3_ff;
   logic        c1_ff, c2_ff, c3_ff;
   logic        s1_ff, s2_ff;
   logic        z1_ff, z2_ff;
   logic [7:0]  e1_ff, e2_ff;
   logic [23:0] m1_ff;
   logic [38:0] p2_ff;
   logic [15:0] pcm3_ff;

   logic        nan_w, big_w, zero_w;
   logic [7:0]  e_in;
   logic [23:0] m_in;
   logic [15:0] pcm_in;

   always_comb begin
      nan_w  = (in_bits[30:23] == 8'hff) && (in_bits[22:0] != 23'd0);
      big_w  = in_bits[30:0] > 31'h3f800000;
      zero_w = in_bits[30:23] == 8'd0;
      e_in   = big_w ? 8'd127 : in_bits[30:23];
      m_in   = big_w ? 24'h800000 : {1'b1, in_bits[22:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_vld; v2_ff <= v1_ff; v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff <= in_cmd; s1_ff <= in_bits[31];
         z1_ff <= nan_w || zero_w; e1_ff <= e_in; m1_ff <= m_in;
         c2_ff <= c1_ff; s2_ff <= s1_ff; z2_ff <= z1_ff; e2_ff <= e1_ff;
         p2_ff <= {15'd0, m1_ff} * 39'd32767;
         c3_ff <= c2_ff; pcm3_ff <= pcm_in;
      end
   end

   // product = p * 2^(e-150); p in [2^37, 2^39); single precision keeps 24 bits
   logic [38:0] keep_w;
   logic        rnd_w;
   logic [39:0] rm_w;
   logic [39:0] mag_w;
   logic [7:0]  sh_w;
   always_comb begin
      // rounding to 24 significant bits: bit 14/15 depends on msb
      if (p2_ff[38]) begin
         rnd_w  = p2_ff[14] && (p2_ff[15] || (p2_ff[13:0] != 14'd0));
         keep_w = {p2_ff[38:15], 15'd0};
         rm_w   = {1'b0, keep_w} + (rnd_w ? 40'h8000 : 40'd0);
      end else begin
         rnd_w  = p2_ff[13] && (p2_ff[14] || (p2_ff[12:0] != 13'd0));
         keep_w = {p2_ff[38:14], 14'd0};
         rm_w   = {1'b0, keep_w} + (rnd_w ? 40'h4000 : 40'd0);
      end
      // value = rm * 2^(e-150); integer part needs e >= 112 to be nonzero
      if (e2_ff < 8'd112) sh_w = 8'd40;
      else sh_w = 8'd150 - e2_ff;
      mag_w = (sh_w >= 8'd40) ? 40'd0 : (rm_w >> sh_w[5:0]);
      if (z2_ff) pcm_in = 16'd0;
      else if (s2_ff) pcm_in = 16'(-mag_w[15:0]);
      else pcm_in = mag_w[15:0];
   end

   assign out_vld = v3_ff;
   assign out_cmd = c3_ff;
   assign out_pcm = pcm3_ff;
endmodule

@@ rtl/core/pcm_wav_stream_writer_top.sv @@
// path: an accepted item passes the three converter stages, the emitter and
// the output register before its first result beat is valid
// output: a sample gives two bytes, a header 44 bytes, an error one byte
// the byte-wide result channel sets the rate; the converter pipeline overlaps it
// reset: synchronous, active high; clears pipeline valids and both registers to zero
module pcm_wav_stream_writer_top (
   input  logic                        clock,
   input  logic                        reset,
   pwsw_stream_if.sink                 req,
   pwsw_stream_if.source               rsp,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [pwsw_pkg::RegWidth-1:0] csr_wdata
);
   logic [30:0] rate_ff, count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= '0;
         count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pwsw_pkg::RegRate:  rate_ff  <= csr_wdata;
            pwsw_pkg::RegCount: count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // precomputed header words, stable while idle
   logic [31:0] payload_len_w, file_size_w, byte_rate_w;
   assign payload_len_w = {count_ff, 1'b0};
   assign file_size_w   = payload_len_w + 32'd36;
   assign byte_rate_w   = {rate_ff, 1'b0};

   // emitter: holds the item leaving the converter and serializes it
   logic        busy_ff, busy_in;
   logic        ecmd_ff;
   logic [15:0] epcm_ff;
   logic [5:0]  idx_ff, idx_in;
   logic        emit_done;
   logic        adv;
   logic        cv;
   logic        ccmd;
   logic [15:0] cpcm;

   // output register stage
   logic                   ov_ff;
   pwsw_pkg::rsp_beat_type ob_ff;
   logic                   o_free;
   assign o_free = !ov_ff || rsp.ready;

   pwsw_conv u_conv (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (req.valid),
      .in_cmd  (req.data.cmd),
      .in_bits (req.data.sample_bits),
      .out_vld (cv),
      .out_cmd (ccmd),
      .out_pcm (cpcm)
   );

   // pipeline advances when the emitter can take the item leaving stage 3
   assign adv       = !cv || !busy_ff || (emit_done && o_free);
   assign req.ready = adv;

   pwsw_pkg::rsp_beat_type beat_w;
   logic [31:0]            word_w;
   always_comb begin
      word_w = 32'd0;
      case (idx_ff[5:2])
         4'd1:  word_w = file_size_w;
         4'd6:  word_w = {1'b0, rate_ff};
         4'd7:  word_w = byte_rate_w;
         4'd10: word_w = payload_len_w;
         default: word_w = 32'd0;
      endcase
      beat_w.error = 1'b0;
      if (ecmd_ff == pwsw_pkg::CmdSample) begin
         beat_w.out_byte = idx_ff[0] ? epcm_ff[15:8] : epcm_ff[7:0];
         beat_w.last     = idx_ff[0];
      end else if (rate_ff == 31'd0) begin
         beat_w.out_byte = 8'd0;
         beat_w.last     = 1'b1;
         beat_w.error    = 1'b1;
      end else begin
         beat_w.out_byte = pwsw_pkg::hdr_const(idx_ff) | word_w[8*idx_ff[1:0] +: 8];
         beat_w.last     = idx_ff == 6'(pwsw_pkg::HdrBytes - 1);
      end
      emit_done = beat_w.last;
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (busy_ff && o_free) begin
         idx_in = idx_ff + 6'd1;
         if (emit_done) busy_in = 1'b0;
      end
      if (adv && cv) begin
         busy_in = 1'b1;
         idx_in  = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (o_free) ov_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && cv) begin
         ecmd_ff <= ccmd;
         epcm_ff <= cpcm;
      end
      if (o_free && busy_ff) ob_ff <= beat_w;
   end

   assign rsp.valid = ov_ff;
   assign rsp.data  = ob_ff;

   // error beats only come with last
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.error |-> rsp.data.last)
      else $error("error beat without last");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result beat changed under stall");

   // emitter index never passes the header length
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < 6'(pwsw_pkg::HdrBytes))
      else $error("emitter index out of range");
endmodule
